/* rtl/serial_link_frame_controller_macros.svh */
// Assertion macros shared by the serial link frame controller checker.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef SERIAL_LINK_FRAME_CONTROLLER_MACROS_SVH
`define SERIAL_LINK_FRAME_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SLFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slfc: implication check failed");

// next-cycle implication
`define SLFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slfc: next-cycle check failed");

`endif

/* rtl/slfc_pkg.sv */
// Shared types and constants of the serial link frame controller.
// No dependencies; imported by the controller, datapath and top level.
package slfc_pkg;

  localparam logic [2:0] FUNC_RAM_RD  = 3'd0;
  localparam logic [2:0] FUNC_RAM_WR  = 3'd1;
  localparam logic [2:0] FUNC_REG_RD  = 3'd2;
  localparam logic [2:0] FUNC_REG_WR  = 3'd3;
  localparam logic [2:0] FUNC_TICK    = 3'd4;
  localparam logic [2:0] FUNC_RX_BYTE = 3'd5;
  localparam logic [2:0] FUNC_RX_POLL = 3'd6;
  localparam logic [2:0] FUNC_TX_PULL = 3'd7;

  localparam logic [3:0] REG_STATUS = 4'd0;
  localparam logic [3:0] REG_CTRL   = 4'd1;
  localparam logic [3:0] REG_START  = 4'd2;
  localparam logic [3:0] REG_RX_WDS = 4'd4;
  localparam logic [3:0] REG_TX_WDS = 4'd5;
  localparam logic [3:0] REG_RX_OFS = 4'd6;
  localparam logic [3:0] REG_TX_OFS = 4'd7;

  localparam logic [15:0] CTL_START_ALL = 16'h0009;
  localparam logic [15:0] CTL_START_CNT = 16'h000d;
  localparam logic [15:0] CTL_HOLD      = 16'h000f;
  localparam int          CTL_SEND_BIT  = 3;
  localparam logic [15:0] STAT_RX_DONE  = 16'h0002;
  localparam logic [15:0] STAT_EMPTY    = 16'h0004;
  localparam logic [15:0] RD_MASK       = 16'h01ff;
  localparam int          SYNC_BIT      = 8;
  localparam int          SYNC_SPAN     = 512;

  localparam logic CFG_LINK_ID = 1'b0;
  localparam logic CFG_LINK_UP = 1'b1;

  typedef logic [4:0] step_t;

  localparam step_t ST_CLR  = 5'd0;
  localparam step_t ST_IDLE = 5'd1;
  localparam step_t ST_DISP = 5'd2;
  localparam step_t ST_RRD  = 5'd3;
  localparam step_t ST_RWR  = 5'd4;
  localparam step_t ST_TICK = 5'd5;
  localparam step_t ST_TCK2 = 5'd6;
  localparam step_t ST_BRED = 5'd7;
  localparam step_t ST_SRD  = 5'd8;
  localparam step_t ST_SCK  = 5'd9;
  localparam step_t ST_BCHK = 5'd10;
  localparam step_t ST_BH0  = 5'd11;
  localparam step_t ST_BH1  = 5'd12;
  localparam step_t ST_BH2  = 5'd13;
  localparam step_t ST_BRD  = 5'd14;
  localparam step_t ST_BWL  = 5'd15;
  localparam step_t ST_BWH  = 5'd16;
  localparam step_t ST_RXW  = 5'd17;
  localparam step_t ST_UCHK = 5'd18;
  localparam step_t ST_UR1  = 5'd19;
  localparam step_t ST_UR2  = 5'd20;
  localparam step_t ST_UCK  = 5'd21;
  localparam step_t ST_URD  = 5'd22;
  localparam step_t ST_UL   = 5'd23;
  localparam step_t ST_UH   = 5'd24;
  localparam step_t ST_UEND = 5'd25;
  localparam step_t ST_TXR  = 5'd26;
  localparam step_t ST_FIN  = 5'd27;

  typedef struct packed {
    step_t step;
    logic  latch;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       link_up;
    logic       ctl_hold;
    logic       build_go;
    logic       use_search;
    logic       ptr_ge;
    logic       sync_hit;
    logic       srch_last;
    logic       words_zero;
    logic       rx_full;
    logic       status_two;
    logic       tx_pending;
    logic       word_last;
    logic       clr_last;
  } stat_t;

endpackage

/* rtl/slfc_ctrl.sv */
// Sequencing state machine of the serial link frame controller.
// Depends on slfc_pkg; drives slfc_dpath through cmd_t, reads stat_t.
module slfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output slfc_pkg::cmd_t cmd,
  input  slfc_pkg::stat_t st
);
  import slfc_pkg::*;

  step_t state, state_next;
  logic  out_free;

  assign out_free     = !out_valid || out_ready;
  assign in_ready     = (state == ST_IDLE);
  assign cmd.step     = state;
  assign cmd.latch    = (state == ST_IDLE) && in_valid;
  assign cmd.out_load = (state == ST_FIN) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLR:  if (st.clr_last) state_next = ST_IDLE;
      ST_IDLE: if (in_valid) state_next = ST_DISP;
      ST_DISP: begin
        unique case (st.func)
          FUNC_RAM_RD:  state_next = ST_RRD;
          FUNC_RAM_WR:  state_next = ST_RWR;
          FUNC_TICK:    state_next = st.link_up ? ST_TICK : ST_FIN;
          FUNC_RX_BYTE: state_next = st.link_up ? ST_RXW : ST_FIN;
          FUNC_TX_PULL: state_next = st.tx_pending ? ST_TXR : ST_FIN;
          default:      state_next = ST_FIN;
        endcase
      end
      ST_RRD:  state_next = ST_FIN;
      ST_RWR:  state_next = ST_FIN;
      ST_TICK: state_next = st.ctl_hold ? ST_FIN : ST_TCK2;
      ST_TCK2: state_next = st.build_go ? ST_BRED : ST_FIN;
      ST_BRED: if (!st.ptr_ge) state_next = st.use_search ? ST_SRD : ST_BCHK;
      ST_SRD:  state_next = ST_SCK;
      ST_SCK:  state_next = (st.sync_hit || st.srch_last) ? ST_BCHK : ST_SRD;
      ST_BCHK: state_next = st.words_zero ? ST_FIN : ST_BH0;
      ST_BH0:  state_next = ST_BH1;
      ST_BH1:  state_next = ST_BH2;
      ST_BH2:  state_next = ST_BRD;
      ST_BRD:  state_next = ST_BWL;
      ST_BWL:  state_next = ST_BWH;
      ST_BWH:  state_next = st.word_last ? ST_FIN : ST_BRD;
      ST_RXW:  state_next = st.rx_full ? ST_UCHK : ST_FIN;
      ST_UCHK: state_next = st.status_two ? ST_FIN : ST_UR1;
      ST_UR1:  state_next = ST_UR2;
      ST_UR2:  state_next = ST_UCK;
      ST_UCK:  state_next = st.words_zero ? ST_UEND : ST_URD;
      ST_URD:  state_next = ST_UL;
      ST_UL:   state_next = ST_UH;
      ST_UH:   state_next = st.word_last ? ST_UEND : ST_URD;
      ST_UEND: state_next = ST_FIN;
      ST_TXR:  state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/slfc_dpath.sv */
// Datapath of the serial link frame controller: shared RAM, frame buffer,
// register file, counters and result registers. Depends on slfc_pkg.
module slfc_dpath #(
  parameter int FRAME_BYTES = 512,
  parameter int RAM_WORDS   = 16384,
  parameter int RX_BASE     = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  slfc_pkg::cmd_t  cmd,
  output slfc_pkg::stat_t st,
  input  logic [2:0]      func,
  input  logic [13:0]     address,
  input  logic [15:0]     write_data,
  input  logic [15:0]     byte_mask,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  output logic [15:0]     read_data,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  output logic            irq_assert
);
  import slfc_pkg::*;

  localparam int RAW       = $clog2(RAM_WORDS);
  localparam int PW        = (RAW + 1 > 15) ? RAW + 1 : 15;
  localparam int FBW       = $clog2(FRAME_BYTES);
  localparam int CW        = $clog2(FRAME_BYTES + 1);
  localparam int MAX_WORDS = (FRAME_BYTES - 3) / 2;
  localparam int JW        = ($clog2(MAX_WORDS + 1) > 10) ? $clog2(MAX_WORDS + 1) : 10;
  localparam int RX_PTR0   = RX_BASE % RAM_WORDS;

  logic [15:0] ram_mem [RAM_WORDS];
  logic [7:0]  fb_mem  [FRAME_BYTES];
  logic [15:0] ram_q;
  logic [7:0]  fb_q;
  logic [15:0] regs [16];

  logic [2:0]  l_func;
  logic [13:0] l_addr;
  logic [15:0] l_data, l_mask;
  logic [7:0]  l_rx;
  logic [7:0]  link_id;
  logic        link_up;

  logic [PW-1:0] ptr, base;
  logic [JW-1:0] j;
  logic [15:0]   words;
  logic [7:0]    lo;
  logic [CW-1:0] pos, rx_cnt, tx_idx;
  logic          tx_pend;

  logic [15:0] res_rd;
  logic        res_tv, res_tl, res_irq;
  logic [7:0]  res_tb;

  logic [PW-1:0]  addr_ext, addr_mod, ptr_inc;
  logic [CW-1:0]  rx_wi, rx_inc;
  logic [15:0]    words_in, words_sat;
  logic           ram_we;
  logic [RAW-1:0] ram_a;
  logic [15:0]    ram_wd;
  logic           fb_we;
  logic [FBW-1:0] fb_wa, fb_ra;
  logic [7:0]     fb_wd;

  assign addr_ext = PW'(l_addr);
  assign addr_mod = (addr_ext >= PW'(RAM_WORDS)) ? addr_ext - PW'(RAM_WORDS) : addr_ext;
  assign ptr_inc  = (ptr == PW'(RAM_WORDS - 1)) ? '0 : ptr + 1'b1;
  assign rx_wi    = (rx_cnt >= CW'(FRAME_BYTES)) ? '0 : rx_cnt;
  assign rx_inc   = rx_wi + 1'b1;

  // word count source: frame header on unpack, tx words or search on send
  assign words_in  = (cmd.step == ST_UR2) ? {words[15:8], fb_q} : words;
  assign words_sat = (words_in > 16'(MAX_WORDS)) ? 16'(MAX_WORDS) : words_in;

  assign st.func       = l_func;
  assign st.link_up    = link_up;
  assign st.ctl_hold   = (regs[REG_CTRL] == CTL_HOLD);
  assign st.build_go   = regs[REG_CTRL][CTL_SEND_BIT] && regs[REG_START][0];
  assign st.use_search = regs[REG_START][1];
  assign st.ptr_ge     = (ptr >= PW'(RAM_WORDS));
  assign st.sync_hit   = ram_q[SYNC_BIT];
  assign st.srch_last  = (j == JW'(SYNC_SPAN - 1));
  assign st.words_zero = (words == 16'd0);
  assign st.rx_full    = (rx_inc == CW'(FRAME_BYTES));
  assign st.status_two = (regs[REG_STATUS] == STAT_RX_DONE);
  assign st.tx_pending = tx_pend;
  assign st.word_last  = ((16'(j) + 16'd1) == words);
  assign st.clr_last   = (pos == CW'(FRAME_BYTES - 1));

  // memory port steering
  always_comb begin
    ram_we = 1'b0;
    ram_wd = (ram_q & ~l_mask) | (l_data & l_mask);
    ram_a  = ptr[RAW-1:0];
    fb_we  = 1'b0;
    fb_wa  = pos[FBW-1:0];
    fb_wd  = 8'd0;
    fb_ra  = pos[FBW-1:0];
    unique case (cmd.step)
      ST_CLR:  fb_we = 1'b1;
      ST_DISP: begin
        ram_a = addr_mod[RAW-1:0];
        fb_ra = tx_idx[FBW-1:0];
      end
      ST_RRD:  ram_a = addr_mod[RAW-1:0];
      ST_RWR: begin
        ram_a  = addr_mod[RAW-1:0];
        ram_we = 1'b1;
      end
      ST_BH0: begin
        fb_we = 1'b1;
        fb_wa = '0;
        fb_wd = link_id;
      end
      ST_BH1: begin
        fb_we = 1'b1;
        fb_wa = FBW'(1);
        fb_wd = words[7:0];
      end
      ST_BH2: begin
        fb_we = 1'b1;
        fb_wa = FBW'(2);
        fb_wd = words[15:8];
      end
      ST_BWL: begin
        fb_we = 1'b1;
        fb_wd = ram_q[7:0];
      end
      ST_BWH: begin
        fb_we = 1'b1;
        fb_wa = pos[FBW-1:0] + 1'b1;
        fb_wd = ram_q[15:8] | {7'd0, st.word_last};
      end
      ST_RXW: begin
        fb_we = 1'b1;
        fb_wa = rx_wi[FBW-1:0];
        fb_wd = l_rx;
      end
      ST_UCHK: fb_ra = FBW'(2);
      ST_UR1:  fb_ra = FBW'(1);
      ST_UL:   fb_ra = pos[FBW-1:0] + 1'b1;
      ST_UH: begin
        ram_we = 1'b1;
        ram_wd = {fb_q, lo};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_a] <= ram_wd;
    ram_q <= ram_mem[ram_a];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    fb_q <= fb_mem[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) regs[i] <= 16'd0;
      link_id <= 8'd0;
      link_up <= 1'b1;
      pos     <= '0;
      rx_cnt  <= '0;
      tx_idx  <= '0;
      tx_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_LINK_ID) link_id <= cfg_data;
        else link_up <= cfg_data[0];
      end
      if (cmd.latch) begin
        l_func  <= func;
        l_addr  <= address;
        l_data  <= write_data;
        l_mask  <= byte_mask;
        l_rx    <= rx_byte;
        res_rd  <= 16'd0;
        res_tv  <= 1'b0;
        res_tb  <= 8'd0;
        res_tl  <= 1'b0;
        res_irq <= 1'b0;
      end
      if (cmd.out_load) begin
        read_data  <= res_rd;
        tx_valid   <= res_tv;
        tx_byte    <= res_tb;
        tx_last    <= res_tl;
        irq_assert <= res_irq;
      end
      unique case (cmd.step)
        ST_CLR: pos <= pos + 1'b1;
        ST_DISP: begin
          case (l_func)
            FUNC_REG_RD: res_rd <= regs[l_addr[3:0]];
            FUNC_REG_WR: begin
              if (l_addr[3:0] == REG_STATUS && l_data == 16'd0)
                regs[REG_STATUS] <= STAT_EMPTY;
              else
                regs[l_addr[3:0]] <= l_data;
            end
            FUNC_RX_POLL: begin
              if (link_up && !st.status_two) regs[REG_STATUS] <= STAT_EMPTY;
            end
            FUNC_TX_PULL: begin
              if (!tx_pend) tx_idx <= '0;
            end
            default: ;
          endcase
        end
        ST_RRD: res_rd <= ram_q & RD_MASK;
        ST_TICK: begin
          case (regs[REG_CTRL])
            CTL_START_ALL: regs[REG_START] <= regs[REG_START] | 16'h0003;
            CTL_START_CNT: begin
              if (regs[REG_TX_WDS] != 16'd0)
                regs[REG_START] <= regs[REG_START] | 16'h0001;
            end
            default: ;
          endcase
        end
        ST_TCK2: ptr <= PW'(regs[REG_TX_OFS][15:1]);
        ST_BRED: begin
          if (st.ptr_ge) begin
            ptr <= ptr - PW'(RAM_WORDS);
          end else begin
            base <= ptr;
            j    <= '0;
            if (!st.use_search) words <= regs[REG_TX_WDS];
          end
        end
        ST_SCK: begin
          if (st.sync_hit) begin
            words <= 16'(j) + 16'd1;
          end else if (st.srch_last) begin
            words <= 16'd0;
          end else begin
            j   <= j + 1'b1;
            ptr <= ptr_inc;
          end
        end
        ST_BCHK: begin
          words <= words_sat;
          ptr   <= base;
          j     <= '0;
          pos   <= CW'(3);
        end
        ST_BWH: begin
          pos <= pos + CW'(2);
          j   <= j + 1'b1;
          ptr <= ptr_inc;
          if (st.word_last) begin
            regs[REG_START] <= regs[REG_START] ^ 16'h0001;
            tx_pend <= 1'b1;
            tx_idx  <= '0;
          end
        end
        ST_RXW: rx_cnt <= st.rx_full ? '0 : rx_inc;
        ST_UR1: words[15:8] <= fb_q;
        ST_UR2: begin
          words <= words_sat;
          j     <= '0;
          pos   <= CW'(3);
          ptr   <= PW'(RX_PTR0);
        end
        ST_UL: lo <= fb_q;
        ST_UH: begin
          pos <= pos + CW'(2);
          j   <= j + 1'b1;
          ptr <= ptr_inc;
        end
        ST_UEND: begin
          regs[REG_STATUS] <= STAT_RX_DONE;
          regs[REG_RX_WDS] <= words;
          regs[REG_RX_OFS] <= words;
          res_irq <= 1'b1;
        end
        ST_TXR: begin
          res_tv <= 1'b1;
          res_tb <= fb_q;
          if (tx_idx == CW'(FRAME_BYTES - 1)) begin
            res_tl  <= 1'b1;
            tx_pend <= 1'b0;
            tx_idx  <= '0;
          end else begin
            tx_idx <= tx_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/serial_link_frame_controller.sv */
// Serial link frame controller: top level joining sequencer and datapath.
// Depends on slfc_pkg, slfc_ctrl and slfc_dpath.
//
// Usage notes:
// - Command channel (in_valid/in_ready) carries one beat per bus access,
//   frame tick, received byte, empty poll or transmit pull (func).
// - Result channel (out_valid/out_ready) returns exactly one beat per
//   command: read_data for reads, tx_valid/tx_byte/tx_last for pulls,
//   irq_assert when a received frame lands in RAM at RX_BASE.
// - Config channel (cfg_valid/cfg_ready, always ready): index 0 link id,
//   index 1 link up. Write only while the block is idle.
// - One item at a time. Register ops, polls, idle pulls, and ticks or rx
//   bytes on a down link go from dispatch straight to the result; RAM
//   ops, rx bytes and pending pulls pass through an access state first. A
//   send walks RAM word by word, after a sync-bit search when selected; a
//   frame-ending rx byte, unless rx done is still set, unpacks word by
//   word. The single-port RAM and frame buffer read port pace both walks.
// - After reset the frame buffer is cleared, one byte a cycle, across
//   all FRAME_BYTES bytes; in_ready stays low meanwhile.
// - A stalled receiver holds the result beat in the output register; the
//   next command is still taken and runs up to its result, then waits.
module serial_link_frame_controller #(
  parameter int FRAME_BYTES = 512,
  parameter int RAM_WORDS   = 16384,
  parameter int RX_BASE     = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [13:0] address,
  input  logic [15:0] write_data,
  input  logic [15:0] byte_mask,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] read_data,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic        irq_assert,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import slfc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // config writes never stall
  assign cfg_ready = 1'b1;

  slfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  slfc_dpath #(
    .FRAME_BYTES (FRAME_BYTES),
    .RAM_WORDS   (RAM_WORDS),
    .RX_BASE     (RX_BASE)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .func       (func),
    .address    (address),
    .write_data (write_data),
    .byte_mask  (byte_mask),
    .rx_byte    (rx_byte),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .read_data  (read_data),
    .tx_valid   (tx_valid),
    .tx_byte    (tx_byte),
    .tx_last    (tx_last),
    .irq_assert (irq_assert)
  );

endmodule

/* rtl/slfc_checker.sv */
// Port-level checks on the serial link frame controller result channel.
// Depends on serial_link_frame_controller_macros.svh; bound to the top level.
`include "serial_link_frame_controller_macros.svh"

module slfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] read_data,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic        tx_last,
  input logic        irq_assert
);

  `SLFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SLFC_ASSERT_IMP(a_last_is_byte, out_valid && tx_last, tx_valid)
  `SLFC_ASSERT_IMP(a_idle_tx_zero, out_valid && !tx_valid, tx_byte == 8'd0 && !tx_last)
  `SLFC_ASSERT_IMP(a_no_read_mix, out_valid && (tx_valid || irq_assert), read_data == 16'd0)

endmodule

bind serial_link_frame_controller slfc_checker u_slfc_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_data  (read_data),
  .tx_valid   (tx_valid),
  .tx_byte    (tx_byte),
  .tx_last    (tx_last),
  .irq_assert (irq_assert)
);
